// ===== rtl/core/spq3_pkg.sv =====
package spq3_pkg;

  // Queue geometry
  localparam int QUEUE_DEPTH = 128;
  localparam int NUM_CLASSES = 3;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH   = NUM_CLASSES * QUEUE_DEPTH;
  localparam int MEM_AW      = $clog2(MEM_DEPTH);

  // Field widths
  localparam int TICKET_W = 16;
  localparam int TAG_W    = 16;
  localparam int TIME_W   = 32;
  localparam int SUM_W    = 48;
  localparam int COUNT_W  = 16;
  localparam int ENTRY_W  = TICKET_W + TAG_W + TIME_W;

  // Stream widths
  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 152;

  // Result status codes
  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_BAD_CLS  = 3'd1,
    ST_SERVED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture input request, clear result fields
    logic arrive;    // ticket draw and enqueue
    logic head_rd;   // read head entry of first busy class
    logic srv_upd;   // dequeue, wait time, served count
    logic srv_acc;   // wait sum accumulate
    logic nxt_rd;    // latch next class for result
    logic load_out;  // move result into output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_kind;   // kind of request offered on the input
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== rtl/core/strict_priority_three_class_queue_core.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: class, tag, time
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser: status; tdata: result fields
//
// An arrival runs ARRIVE, NXT_RD, FINISH; a serve runs SRV_RD, SRV_UPD, SRV_ACC,
// NXT_RD, FINISH. The steps are set by the entry memory with a registered read,
// read for the served head and again for the next head, and by the wait-sum add.
// rst_ni clears pointers, occupancy and totals at once; ticket restarts at 1.
// A result waits in the output register while the next request is taken;
// it stalls only when a second result is ready before the first is taken.
module strict_priority_three_class_queue_core
  import spq3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [1:0] priority_req, [17:2] record_tag, [49:18] now_time, rest zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] kind
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] ticket, [17:16] served_class, [33:18] served_tag, [65:34] wait_time,
  // [113:66] class_wait_total, [129:114] class_served_total,
  // [131:130] next_class, [147:132] next_ticket, rest zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]           m_axis_tuser
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  spq3_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  spq3_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== rtl/core/spq3_ctrl.sv =====
module spq3_ctrl
  import spq3_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_axis_tvalid,
  output logic     s_axis_tready,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_ARRIVE  = 7'b0000010,
    S_SRV_RD  = 7'b0000100,
    S_SRV_UPD = 7'b0001000,
    S_SRV_ACC = 7'b0010000,
    S_NXT_RD  = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load_in = 1'b1;
          state_d       = stat_i.in_kind ? S_SRV_RD : S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        cmd_o.arrive = 1'b1;
        state_d      = S_NXT_RD;
      end
      S_SRV_RD: begin
        cmd_o.head_rd = 1'b1;
        state_d       = S_SRV_UPD;
      end
      S_SRV_UPD: begin
        cmd_o.srv_upd = 1'b1;
        state_d       = S_SRV_ACC;
      end
      S_SRV_ACC: begin
        cmd_o.srv_acc = 1'b1;
        state_d       = S_NXT_RD;
      end
      S_NXT_RD: begin
        cmd_o.head_rd = 1'b1;
        cmd_o.nxt_rd  = 1'b1;
        state_d       = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/spq3_datapath.sv =====
module spq3_datapath
  import spq3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]           m_axis_tuser
);

  function automatic logic [MEM_AW-1:0] mem_addr(logic [1:0] idx, logic [IDX_W-1:0] slot);
    mem_addr = MEM_AW'(idx) * MEM_AW'(QUEUE_DEPTH) + MEM_AW'(slot);
  endfunction

  function automatic logic [IDX_W-1:0] slot_inc(logic [IDX_W-1:0] slot);
    slot_inc = (slot == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : slot + IDX_W'(1);
  endfunction

  // Captured request
  logic [1:0]        prio_q;
  logic [TAG_W-1:0]  tag_q;
  logic [TIME_W-1:0] now_q;

  // Queue state
  logic [IDX_W-1:0]   head_q [NUM_CLASSES];
  logic [IDX_W-1:0]   tail_q [NUM_CLASSES];
  logic [OCC_W-1:0]   occ_q  [NUM_CLASSES];
  logic [SUM_W-1:0]   wsum_q [NUM_CLASSES];
  logic [COUNT_W-1:0] cnt_q  [NUM_CLASSES];
  logic [TICKET_W-1:0] ticket_q;

  // Entry memory
  logic [ENTRY_W-1:0] mem [MEM_DEPTH];
  logic [ENTRY_W-1:0] rd_q;

  // Serve bookkeeping
  logic               hit_q;
  logic [1:0]         sidx_q;
  logic [TIME_W-1:0]  wait_q;
  logic               nxt_any_q;
  logic [1:0]         nxt_cls_q;

  // Result fields
  status_e            res_status_q;
  logic [TICKET_W-1:0] res_ticket_q;
  logic [1:0]         res_cls_q;
  logic [TAG_W-1:0]   res_tag_q;
  logic [TIME_W-1:0]  res_wait_q;
  logic [SUM_W-1:0]   res_sum_q;
  logic [COUNT_W-1:0] res_cnt_q;

  // Output register
  logic                 out_valid_q;
  logic [M_TDATA_W-1:0] out_data_q;
  logic [2:0]           out_user_q;

  logic         busy_any;
  logic [1:0]   busy_idx;
  logic [1:0]   aidx;
  logic         afull;
  logic [SUM_W:0] sum_ext;
  logic [M_TDATA_W-1:0] out_data_d;
  logic [TICKET_W-1:0]  nxt_ticket;

  // First non-empty class, highest priority first
  always_comb begin
    busy_any = 1'b1;
    busy_idx = 2'd0;
    if (occ_q[0] != '0) begin
      busy_idx = 2'd0;
    end else if (occ_q[1] != '0) begin
      busy_idx = 2'd1;
    end else if (occ_q[2] != '0) begin
      busy_idx = 2'd2;
    end else begin
      busy_any = 1'b0;
    end
  end

  assign aidx    = prio_q - 2'd1;
  assign afull   = (occ_q[aidx] == OCC_W'(QUEUE_DEPTH));
  assign sum_ext = {1'b0, wsum_q[sidx_q]} + (SUM_W + 1)'(wait_q);

  assign stat_o.in_kind  = s_axis_tuser[0];
  assign stat_o.out_free = !out_valid_q || m_axis_tready;

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive && prio_q != 2'd0 && !afull) begin
      mem[mem_addr(aidx, tail_q[aidx])] <= {ticket_q, tag_q, now_q};
    end
    if (cmd_i.head_rd) begin
      rd_q <= mem[mem_addr(busy_idx, head_q[busy_idx])];
    end
  end

  // Request capture and serve bookkeeping
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      prio_q <= s_axis_tdata[1:0];
      tag_q  <= s_axis_tdata[17:2];
      now_q  <= s_axis_tdata[49:18];
    end
    if (cmd_i.head_rd && !cmd_i.nxt_rd) begin
      hit_q  <= busy_any;
      sidx_q <= busy_idx;
    end
    if (cmd_i.srv_upd) begin
      wait_q <= now_q - rd_q[TIME_W-1:0];
    end
    if (cmd_i.nxt_rd) begin
      nxt_any_q <= busy_any;
      nxt_cls_q <= busy_idx + 2'd1;
    end
  end

  // Result fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      res_status_q <= ST_EMPTY;
      res_ticket_q <= '0;
      res_cls_q    <= '0;
      res_tag_q    <= '0;
      res_wait_q   <= '0;
      res_sum_q    <= '0;
      res_cnt_q    <= '0;
    end
    if (cmd_i.arrive) begin
      res_ticket_q <= ticket_q;
      if (prio_q == 2'd0) begin
        res_status_q <= ST_BAD_CLS;
      end else if (afull) begin
        res_status_q <= ST_FULL;
      end else begin
        res_status_q <= ST_QUEUED;
      end
    end
    if (cmd_i.srv_upd && hit_q) begin
      res_status_q <= ST_SERVED;
      res_ticket_q <= rd_q[ENTRY_W-1 -: TICKET_W];
      res_tag_q    <= rd_q[TIME_W +: TAG_W];
      res_cls_q    <= sidx_q + 2'd1;
      res_wait_q   <= now_q - rd_q[TIME_W-1:0];
      res_cnt_q    <= (cnt_q[sidx_q] == '1) ? cnt_q[sidx_q] : cnt_q[sidx_q] + COUNT_W'(1);
    end
    if (cmd_i.srv_acc && hit_q) begin
      res_sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
    end
  end

  // Queue pointers, occupancy, ticket and per-class totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticket_q <= TICKET_W'(1);
      for (int k = 0; k < NUM_CLASSES; k++) begin
        head_q[k] <= '0;
        tail_q[k] <= '0;
        occ_q[k]  <= '0;
        wsum_q[k] <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      if (cmd_i.arrive) begin
        ticket_q <= ticket_q + TICKET_W'(1);
        if (prio_q != 2'd0 && !afull) begin
          tail_q[aidx] <= slot_inc(tail_q[aidx]);
          occ_q[aidx]  <= occ_q[aidx] + OCC_W'(1);
        end
      end
      if (cmd_i.srv_upd && hit_q) begin
        head_q[sidx_q] <= slot_inc(head_q[sidx_q]);
        occ_q[sidx_q]  <= occ_q[sidx_q] - OCC_W'(1);
        if (cnt_q[sidx_q] != '1) begin
          cnt_q[sidx_q] <= cnt_q[sidx_q] + COUNT_W'(1);
        end
      end
      if (cmd_i.srv_acc && hit_q) begin
        wsum_q[sidx_q] <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      end
    end
  end

  // Output packing
  assign nxt_ticket = nxt_any_q ? rd_q[ENTRY_W-1 -: TICKET_W] : '0;
  assign out_data_d = {4'd0, nxt_ticket, (nxt_any_q ? nxt_cls_q : 2'd0),
                       res_cnt_q, res_sum_q, res_wait_q, res_tag_q,
                       res_cls_q, res_ticket_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= out_data_d;
      out_user_q <= res_status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Checks
  load_sets_valid_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |=> m_axis_tvalid)
    else $error("result not presented after load");

  for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_chk
    occ_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
      occ_q[k] <= OCC_W'(QUEUE_DEPTH))
      else $error("class occupancy above depth");
    empty_ptrs_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
      occ_q[k] == '0 |-> head_q[k] == tail_q[k])
      else $error("empty class with head and tail apart");
    wsum_mono_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
      ##1 wsum_q[k] >= $past(wsum_q[k]))
      else $error("class wait sum decreased");
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import spq3_pkg::*;

  // Request kinds and arrival classes
  localparam logic       KIND_ARRIVE = 1'b0;
  localparam logic       KIND_SERVE  = 1'b1;
  localparam logic [1:0] CLS_NONE    = 2'd0;
  localparam logic [1:0] CLS_HIGH    = 2'd1;
  localparam logic [1:0] CLS_MID     = 2'd2;
  localparam logic [1:0] CLS_LOW     = 2'd3;

  localparam int IDLE_PCT      = 35;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_REQS   = 250;
  // arrive/serve pairs sent with both sides always ready
  localparam int NO_IDLE_PAIRS = 100;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic [TAG_W-1:0]    tag;
    logic [TIME_W-1:0]   stamp;
  } slot_t;

  typedef struct packed {
    status_e             status;
    logic [TICKET_W-1:0] ticket;
    logic [1:0]          served_class;
    logic [TAG_W-1:0]    served_tag;
    logic [TIME_W-1:0]   wait_time;
    logic [SUM_W-1:0]    class_wait_total;
    logic [COUNT_W-1:0]  class_served_total;
    logic [1:0]          next_class;
    logic [TICKET_W-1:0] next_ticket;
  } outcome_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [1:0] priority_req, [17:2] record_tag, [49:18] now_time, rest zero
  logic [S_TDATA_W-1:0] s_axis_tdata;
  // [0] kind
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [15:0] ticket, [17:16] served_class, [33:18] served_tag, [65:34] wait_time,
  // [113:66] class_wait_total, [129:114] class_served_total,
  // [131:130] next_class, [147:132] next_ticket, rest zero
  logic [M_TDATA_W-1:0] m_axis_tdata;
  // [2:0] status
  logic [2:0]           m_axis_tuser;

  // Queue state mirrored by the predictor
  slot_t               model_slots [NUM_CLASSES][QUEUE_DEPTH];
  int                  model_head [NUM_CLASSES];
  int                  model_occ [NUM_CLASSES];
  logic [TICKET_W-1:0] model_ticket;
  logic [SUM_W-1:0]    model_wait_sum [NUM_CLASSES];
  logic [COUNT_W-1:0]  model_served [NUM_CLASSES];

  outcome_t outcome_fifo[$];
  int       error_count;
  bit       idle_en;

  strict_priority_three_class_queue_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Lowest-numbered class with entries waiting, as 0..2, or -1
  function automatic int first_busy_class();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (model_occ[c] != 0) return c;
    end
    return -1;
  endfunction

  // Advance the queue state by one accepted request and queue its outcome
  function automatic void apply_request(input logic kind, input logic [1:0] cls,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [TIME_W-1:0] stamp);
    outcome_t         o;
    int               c;
    int               slot;
    slot_t            head;
    logic [SUM_W:0]   sum;
    o = '0;
    if (kind == KIND_ARRIVE) begin
      // every arrival draws a ticket, queued or not
      o.ticket = model_ticket;
      if (cls == CLS_NONE) begin
        o.status = ST_BAD_CLS;
      end else begin
        c = int'(cls) - 1;
        if (model_occ[c] >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          slot = (model_head[c] + model_occ[c]) % QUEUE_DEPTH;
          model_slots[c][slot] = {model_ticket, tag, stamp};
          model_occ[c]++;
          o.status = ST_QUEUED;
        end
      end
      model_ticket = model_ticket + 1'b1;
    end else begin
      c = first_busy_class();
      if (c < 0) begin
        o.status = ST_EMPTY;
      end else begin
        head = model_slots[c][model_head[c]];
        model_head[c] = (model_head[c] + 1) % QUEUE_DEPTH;
        model_occ[c]--;
        o.status = ST_SERVED;
        o.ticket = head.ticket;
        o.served_class = 2'(c + 1);
        o.served_tag = head.tag;
        o.wait_time = stamp - head.stamp;
        // totals saturate instead of wrapping
        sum = {1'b0, model_wait_sum[c]} + {{(SUM_W - TIME_W + 1){1'b0}}, o.wait_time};
        model_wait_sum[c] = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
        if (model_served[c] != {COUNT_W{1'b1}}) model_served[c] = model_served[c] + 1'b1;
        o.class_wait_total = model_wait_sum[c];
        o.class_served_total = model_served[c];
      end
    end
    // next entry in line
    c = first_busy_class();
    if (c >= 0) begin
      o.next_class = 2'(c + 1);
      o.next_ticket = model_slots[c][model_head[c]].ticket;
    end
    outcome_fifo.push_back(o);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Offer one request and wait until it is taken
  task automatic send_request(input logic kind, input logic [1:0] cls,
                              input logic [TAG_W-1:0] tag, input logic [TIME_W-1:0] stamp);
    @(negedge clk_i);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(S_TDATA_W - 2 - TAG_W - TIME_W){1'b0}}, stamp, tag, cls};
    s_axis_tuser <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_request(kind, cls, tag, stamp);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_for_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (outcome_fifo.size() != 0) @(posedge clk_i);
  endtask

  // Serve until all classes are empty, then one serve on empty queues
  task automatic drain_model_queues();
    while (first_busy_class() >= 0) begin
      send_request(KIND_SERVE, 2'($urandom), 16'($urandom), 32'($urandom));
    end
    send_request(KIND_SERVE, 2'($urandom), 16'($urandom), 32'($urandom));
    wait_for_drain();
  endtask

  // Field extremes, every status but full, priority order and wrapped wait time
  task automatic test_directed();
    send_request(KIND_SERVE,  CLS_LOW,  16'hFFFF, 32'hFFFF_FFFF);
    send_request(KIND_ARRIVE, CLS_NONE, 16'h0000, 32'h0000_0000);
    send_request(KIND_ARRIVE, CLS_LOW,  16'hFFFF, 32'h0000_0000);
    send_request(KIND_ARRIVE, CLS_MID,  16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_ARRIVE, CLS_HIGH, 16'hA5A5, 32'hFFFF_FFF0);
    send_request(KIND_ARRIVE, CLS_HIGH, 16'h5A5A, 32'h0000_0100);
    // high class first; first wait wraps through zero
    send_request(KIND_SERVE,  CLS_NONE, 16'h0000, 32'h0000_0010);
    send_request(KIND_SERVE,  CLS_MID,  16'hFFFF, 32'h0000_0200);
    send_request(KIND_SERVE,  CLS_HIGH, 16'h1234, 32'h0000_0000);
    send_request(KIND_SERVE,  CLS_LOW,  16'h0000, 32'hFFFF_FFFF);
    send_request(KIND_SERVE,  CLS_NONE, 16'h0000, 32'h0000_0000);
    send_request(KIND_ARRIVE, CLS_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    wait_for_drain();
  endtask

  // Fill the low class past its depth, add higher classes, then empty everything
  task automatic test_class_full();
    for (int n = 0; n < QUEUE_DEPTH + 2; n++) begin
      send_request(KIND_ARRIVE, CLS_LOW, 16'($urandom), 32'($urandom));
    end
    send_request(KIND_ARRIVE, CLS_MID, 16'($urandom), 32'($urandom));
    send_request(KIND_ARRIVE, CLS_HIGH, 16'($urandom), 32'($urandom));
    drain_model_queues();
  endtask

  // Bursts with varying arrival share, sometimes aimed at one class
  task automatic test_random_traffic();
    int         arrive_pct;
    int         focus;
    int         sent;
    logic       kind;
    logic [1:0] cls;
    sent = 0;
    while (sent < RANDOM_REQS) begin
      case ($urandom_range(3))
        0: arrive_pct = 20;
        1: arrive_pct = 50;
        2: arrive_pct = 80;
        default: arrive_pct = 95;
      endcase
      focus = $urandom_range(3);
      repeat ($urandom_range(40, 120)) begin
        kind = ($urandom_range(99) < arrive_pct) ? KIND_ARRIVE : KIND_SERVE;
        if ($urandom_range(9) == 0) cls = CLS_NONE;
        else if (focus != 0 && $urandom_range(9) < 8) cls = 2'(focus);
        else cls = 2'($urandom_range(1, 3));
        send_request(kind, cls, 16'($urandom), 32'($urandom));
        sent++;
      end
      if ($urandom_range(2) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // Back-to-back max-wait arrive and serve pairs with no idling on either side
  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (NO_IDLE_PAIRS) begin
      send_request(KIND_ARRIVE, CLS_HIGH, 16'($urandom), 32'h0000_0000);
      send_request(KIND_SERVE, 2'($urandom), 16'($urandom), 32'hFFFF_FFFF);
    end
    idle_en = 1'b1;
    // mixed requests with idling back on
    repeat (20) begin
      send_request(1'($urandom), 2'($urandom), 16'($urandom), 32'($urandom));
    end
    wait_for_drain();
  endtask

  // Result ready, stalled at random
  always @(negedge clk_i) begin
    m_axis_tready <= !idle_en || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result with the oldest predicted outcome
  initial begin : result_monitor
    outcome_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (outcome_fifo.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = outcome_fifo.pop_front();
          check_field("status", 64'(m_axis_tuser), 64'(want.status));
          check_field("ticket", 64'(m_axis_tdata[15:0]), 64'(want.ticket));
          check_field("served_class", 64'(m_axis_tdata[17:16]), 64'(want.served_class));
          check_field("served_tag", 64'(m_axis_tdata[33:18]), 64'(want.served_tag));
          check_field("wait_time", 64'(m_axis_tdata[65:34]), 64'(want.wait_time));
          check_field("class_wait_total", 64'(m_axis_tdata[113:66]),
                      64'(want.class_wait_total));
          check_field("class_served_total", 64'(m_axis_tdata[129:114]),
                      64'(want.class_served_total));
          check_field("next_class", 64'(m_axis_tdata[131:130]), 64'(want.next_class));
          check_field("next_ticket", 64'(m_axis_tdata[147:132]), 64'(want.next_ticket));
          check_field("tdata padding", 64'(m_axis_tdata[M_TDATA_W-1:148]), 64'd0);
        end
      end
    end
  end

  // Stop if neither side moves a request for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Test sequence
  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    idle_en = 1'b1;
    error_count = 0;
    model_ticket = 1;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      model_head[c] = 0;
      model_occ[c] = 0;
      model_wait_sum[c] = '0;
      model_served[c] = '0;
    end
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_class_full();
    test_random_traffic();
    test_no_idle();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== strict_priority_three_class_queue_core.f =====
rtl/core/spq3_pkg.sv
rtl/core/spq3_ctrl.sv
rtl/core/spq3_datapath.sv
rtl/core/strict_priority_three_class_queue_core.sv
test/tb_top.sv
